// File: rtl/rse_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and arithmetic helpers of the radial splat explosion renderer
// no dependencies; used by rse_ram's users, rse_pix_pipe and the top level
package rse_pkg;

   localparam int MAX_GROUPS  = 8;
   localparam int MAX_POINTS  = 64;
   localparam int SLOTS       = MAX_GROUPS * MAX_POINTS;
   localparam int SLOT_W      = $clog2(SLOTS);
   localparam int GRP_W       = $clog2(MAX_GROUPS);
   localparam int PT_W        = $clog2(MAX_POINTS);
   localparam int GC_W        = $clog2(MAX_GROUPS + 1);
   localparam int PC_W        = $clog2(MAX_POINTS + 1);
   localparam int TOT_W       = $clog2(SLOTS + 1);
   localparam int GSUM_W      = 13 + PT_W;
   localparam int SQRT_STAGES = 5;
   localparam int DIV_STAGES  = 4;

   localparam logic [1:0] OP_LOAD    = 2'd0;
   localparam logic [1:0] OP_ADVANCE = 2'd1;
   localparam logic [1:0] OP_RENDER  = 2'd2;

   localparam logic [1:0] CSR_BLEND_MODE       = 2'd0;
   localparam logic [1:0] CSR_GROUP_COUNT      = 2'd1;
   localparam logic [1:0] CSR_POINTS_PER_GROUP = 2'd2;
   localparam logic [1:0] CSR_STEP_SIZE        = 2'd3;

   localparam logic [1:0] BLEND_ALT_A = 2'd1;
   localparam logic [1:0] BLEND_ALT_B = 2'd2;

   // floor(n / 10000) for any 32-bit n, as (n * m) >> 45
   localparam logic [31:0] DIV10K_MUL = 32'd3518437209;
   // floor(n / 50) for any 32-bit n, as (n * m) >> 37
   localparam logic [31:0] DIV50_MUL  = 32'd2748779070;

   typedef struct packed {
      logic [18:0] x;
      logic [18:0] y;
      logic [31:0] fine_x;
      logic [31:0] fine_y;
      logic [31:0] radius;
      logic [25:0] frc;
      logic [14:0] dir_x;
      logic [14:0] dir_y;
   } point_type;

   localparam int POINT_W = $bits(point_type);

   typedef struct packed {
      logic valid;
      logic last;
      logic odd;
   } pix_tag_type;

   typedef struct packed {
      logic [21:0] rem;
      logic [19:0] root;
      logic [39:0] val;
   } sqrt_type;

   typedef struct packed {
      logic [18:0] rem;
      logic [31:0] num;
      logic [15:0] q;
   } div_type;

   function automatic logic [18:0] div10k(input logic [31:0] n);
      logic [63:0] p;
      p = {32'd0, n} * {32'd0, DIV10K_MUL};
      return p[63:45];
   endfunction

   // signed division by 10000, truncating toward zero
   function automatic logic [18:0] sdiv10k(input logic [31:0] v);
      logic [31:0] mag;
      logic [18:0] q;
      mag = v[31] ? (~v + 32'd1) : v;
      q   = div10k(mag);
      return v[31] ? (~q + 19'd1) : q;
   endfunction

   // force * 86 / 100 truncated, as (force * 43) / 50
   function automatic logic [25:0] decay(input logic [25:0] f);
      logic [31:0] n;
      logic [63:0] p;
      n = {6'd0, f} * 32'd43;
      p = {32'd0, n} * {32'd0, DIV50_MUL};
      return p[62:37];
   endfunction

   // floor(a / gc) for gc in 1..8 by reciprocal table
   function automatic logic [7:0] avg_div(input logic [10:0] a, input logic [GC_W-1:0] gc);
      logic [14:0] m;
      logic [25:0] p;
      unique case (gc)
         4'd1:    m = 15'd16384;
         4'd2:    m = 15'd8192;
         4'd3:    m = 15'd5462;
         4'd4:    m = 15'd4096;
         4'd5:    m = 15'd3277;
         4'd6:    m = 15'd2731;
         4'd7:    m = 15'd2341;
         4'd8:    m = 15'd2048;
         default: m = 15'd0;
      endcase
      p = {15'd0, a} * {11'd0, m};
      return p[21:14];
   endfunction

   // four digit steps of the integer square root
   function automatic sqrt_type sqrt4(input sqrt_type s);
      sqrt_type    t;
      logic [21:0] trial;
      t = s;
      for (int i = 0; i < 4; i++) begin
         t.rem = {t.rem[19:0], t.val[39:38]};
         t.val = {t.val[37:0], 2'b00};
         trial = {t.root, 2'b01};
         if (t.rem >= trial) begin
            t.rem  = t.rem - trial;
            t.root = {t.root[18:0], 1'b1};
         end else begin
            t.root = {t.root[18:0], 1'b0};
         end
      end
      return t;
   endfunction

   // four quotient bits of a restoring division
   function automatic div_type div4(input div_type s, input logic [17:0] den);
      div_type     t;
      logic [18:0] tt;
      t = s;
      for (int i = 0; i < 4; i++) begin
         tt    = {t.rem[17:0], t.num[31]};
         t.num = {t.num[30:0], 1'b0};
         if (tt >= {1'b0, den}) begin
            t.rem = tt - {1'b0, den};
            t.q   = {t.q[14:0], 1'b1};
         end else begin
            t.rem = tt;
            t.q   = {t.q[14:0], 1'b0};
         end
      end
      return t;
   endfunction

endpackage

// File: rtl/rse_ram.sv
`timescale 1ns / 1ps
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module rse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// File: rtl/rse_pix_pipe.sv
`timescale 1ns / 1ps
// per-point falloff pipeline: distance, integer square root, falloff division
// depends on rse_pkg
module rse_pix_pipe
   import rse_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  pix_tag_type in_tag,
   input  point_type   in_pt,
   input  logic [10:0] pix_x,
   input  logic [10:0] pix_y,
   output pix_tag_type out_tag,
   output logic [15:0] out_value
);
   logic [18:0] rdiv_c;
   logic [18:0] fdiv_c;
   logic [19:0] ddx_c;
   logic [19:0] ddy_c;
   logic [17:0] adx_c;
   logic [17:0] ady_c;

   pix_tag_type tag1_ff;
   logic [18:0] r1_ff;
   logic [12:0] f1_ff;
   logic [17:0] dx1_ff;
   logic [17:0] dy1_ff;

   logic        inside_c;
   logic [36:0] sq_c;

   pix_tag_type tag2_ff;
   logic        in2_ff;
   logic [36:0] sq2_ff;
   logic [17:0] r2_ff;
   logic [12:0] f2_ff;

   sqrt_type    sq_init_c;
   sqrt_type    sq_st_ff [SQRT_STAGES];
   pix_tag_type tg_sq_ff [SQRT_STAGES];
   logic        in_sq_ff [SQRT_STAGES];
   logic [17:0] r_sq_ff  [SQRT_STAGES];
   logic [12:0] f_sq_ff  [SQRT_STAGES];

   logic [18:0] d_c;
   logic        hit_c;
   logic [17:0] diff_c;

   pix_tag_type tag8_ff;
   logic [31:0] num8_ff;
   logic [17:0] den8_ff;

   div_type     dv_init_c;
   div_type     dv_st_ff  [DIV_STAGES];
   logic [17:0] den_dv_ff [DIV_STAGES];
   pix_tag_type tg_dv_ff  [DIV_STAGES];

   // stage 1: scale down radius and force, distances
   assign rdiv_c = sdiv10k(in_pt.radius);
   assign fdiv_c = div10k({6'd0, in_pt.frc});
   assign ddx_c  = {9'd0, pix_x} - {in_pt.x[18], in_pt.x};
   assign ddy_c  = {9'd0, pix_y} - {in_pt.y[18], in_pt.y};
   assign adx_c  = ddx_c[19] ? 18'(~ddx_c + 20'd1) : ddx_c[17:0];
   assign ady_c  = ddy_c[19] ? 18'(~ddy_c + 20'd1) : ddy_c[17:0];

   // stage 2: box test and squared distance
   assign inside_c = !r1_ff[18] && (r1_ff != 19'd0) && ({1'b0, dx1_ff} < r1_ff)
                     && ({1'b0, dy1_ff} < r1_ff);
   assign sq_c = ({19'd0, dx1_ff} * {19'd0, dx1_ff}) + ({19'd0, dy1_ff} * {19'd0, dy1_ff});

   assign sq_init_c.rem  = '0;
   assign sq_init_c.root = '0;
   assign sq_init_c.val  = {3'd0, sq2_ff};

   // after the root: hit test and falloff numerator
   assign d_c    = sq_st_ff[SQRT_STAGES-1].root[18:0];
   assign hit_c  = in_sq_ff[SQRT_STAGES-1] && ({1'b0, r_sq_ff[SQRT_STAGES-1]} > d_c);
   assign diff_c = r_sq_ff[SQRT_STAGES-1] - d_c[17:0];

   assign dv_init_c.rem = {3'd0, num8_ff[31:16]};
   assign dv_init_c.num = {num8_ff[15:0], 16'd0};
   assign dv_init_c.q   = '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag8_ff <= '0;
         for (int i = 0; i < SQRT_STAGES; i++) begin
            tg_sq_ff[i] <= '0;
         end
         for (int i = 0; i < DIV_STAGES; i++) begin
            tg_dv_ff[i] <= '0;
         end
      end else begin
         tag1_ff     <= in_tag;
         tag2_ff     <= tag1_ff;
         tg_sq_ff[0] <= tag2_ff;
         for (int i = 1; i < SQRT_STAGES; i++) begin
            tg_sq_ff[i] <= tg_sq_ff[i-1];
         end
         tag8_ff     <= tg_sq_ff[SQRT_STAGES-1];
         tg_dv_ff[0] <= tag8_ff;
         for (int i = 1; i < DIV_STAGES; i++) begin
            tg_dv_ff[i] <= tg_dv_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      r1_ff  <= rdiv_c;
      f1_ff  <= fdiv_c[12:0];
      dx1_ff <= adx_c;
      dy1_ff <= ady_c;

      in2_ff <= inside_c;
      sq2_ff <= sq_c;
      r2_ff  <= r1_ff[17:0];
      f2_ff  <= f1_ff;

      sq_st_ff[0] <= sqrt4(sq_init_c);
      in_sq_ff[0] <= in2_ff;
      r_sq_ff[0]  <= r2_ff;
      f_sq_ff[0]  <= f2_ff;
      for (int i = 1; i < SQRT_STAGES; i++) begin
         sq_st_ff[i] <= sqrt4(sq_st_ff[i-1]);
         in_sq_ff[i] <= in_sq_ff[i-1];
         r_sq_ff[i]  <= r_sq_ff[i-1];
         f_sq_ff[i]  <= f_sq_ff[i-1];
      end

      num8_ff <= hit_c ? ({14'd0, diff_c} * {19'd0, f_sq_ff[SQRT_STAGES-1]}) : 32'd0;
      den8_ff <= hit_c ? r_sq_ff[SQRT_STAGES-1] : 18'd1;

      dv_st_ff[0]  <= div4(dv_init_c, den8_ff);
      den_dv_ff[0] <= den8_ff;
      for (int i = 1; i < DIV_STAGES; i++) begin
         dv_st_ff[i]  <= div4(dv_st_ff[i-1], den_dv_ff[i-1]);
         den_dv_ff[i] <= den_dv_ff[i-1];
      end
   end

   assign out_tag   = tg_dv_ff[DIV_STAGES-1];
   assign out_value = dv_st_ff[DIV_STAGES-1].q;
endmodule

// File: rtl/radial_splat_explosion_renderer.sv
`timescale 1ns / 1ps
// top level of the radial splat explosion renderer: point table, sweep control,
// advance pipeline and pixel accumulation; depends on rse_pkg, rse_ram, rse_pix_pipe
//
// channel   direction  handshake             payload
// req_      in         req_valid/req_stall   op, slot, position, radius, force, direction
// rsp_      out        rsp_valid/rsp_stall   intensity
// csr_      in         csr_valid/csr_ready   csr_index, csr_wdata
//
// a load request writes its table slot when accepted; advance and render sweep one
// table slot per cycle through the single read port, n = groups*points slots in all.
// reset is synchronous; the point table is not cleared, and the user must see that it
// is read only after loading: the block itself does not enforce this.
// req_stall is high while a sweep runs or its intensity waits for the output register;
// a finished intensity waits in that register while the next request is taken.
module radial_splat_explosion_renderer
   import rse_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [2:0]  req_group_index,
   input  logic [5:0]  req_point_index,
   input  logic [10:0] req_pos_x,
   input  logic [10:0] req_pos_y,
   input  logic [23:0] req_radius_in,
   input  logic [25:0] req_force_in,
   input  logic signed [14:0] req_dir_x,
   input  logic signed [14:0] req_dir_y,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_intensity,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata
);
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_ADV   = 5'b00010,
      ST_RND   = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   typedef struct packed {
      logic              adv;
      logic              rnd;
      logic              last;
      logic              odd;
      logic [SLOT_W-1:0] slot;
   } iss_type;

   // configuration
   logic [1:0]  blend_ff;
   logic [3:0]  gcount_ff;
   logic [6:0]  ppg_ff;
   logic [23:0] step_ff;
   logic [10:0] step_q_ff;
   logic [13:0] step_r_ff;
   logic [18:0] step_q_c;
   logic        csr_we;

   // control
   state_type         state_ff, state_in;
   logic [GRP_W-1:0]  sg_ff, sg_in;
   logic [PT_W-1:0]   sp_ff, sp_in;
   logic              rnd_ff, rnd_in;
   logic [TOT_W-1:0]  total_ff, total_in;
   logic [TOT_W-1:0]  retired_ff, retired_in;
   logic [10:0]       px_ff, px_in;
   logic [10:0]       py_ff, py_in;
   logic signed [12:0] acc_ff, acc_in;
   logic [GSUM_W-1:0] gsum_ff, gsum_in;
   iss_type           iss_ff, iss_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_int_ff, rsp_int_in;

   logic              accept;
   logic [GC_W-1:0]   act_gc;
   logic [PC_W-1:0]   act_pc;
   logic [TOT_W-1:0]  total_c;
   logic              last_p_c;
   logic              last_g_c;
   logic              alt_mode;
   logic [7:0]        final_c;

   // table
   logic              load_we;
   logic [SLOT_W-1:0] load_slot;
   point_type         load_pt;
   logic              wr_en;
   logic [SLOT_W-1:0] wr_addr;
   point_type         wr_pt;
   logic [SLOT_W-1:0] rd_addr;
   logic [POINT_W-1:0] rd_bits;
   point_type         rd_pt;

   // advance pipeline
   logic signed [26:0] ax_c, ay_c;
   logic [14:0]        mdx_c, mdy_c;
   logic [27:0]        bx_c, by_c;
   logic               dec_c;
   logic signed [32:0] rad_c;

   logic               a1_v_ff;
   logic [SLOT_W-1:0]  a1_slot_ff;
   point_type          a1_pt_ff;
   logic signed [26:0] a1_ax_ff, a1_ay_ff;
   logic [27:0]        a1_bx_ff, a1_by_ff;
   logic               a1_dec_ff;
   logic [31:0]        a1_rad_ff;

   logic [18:0]        bqx_c, bqy_c;
   logic [31:0]        dlx_c, dly_c;

   logic               a2_v_ff;
   logic [SLOT_W-1:0]  a2_slot_ff;
   point_type          a2_pt_ff, a2_pt_in;
   logic [31:0]        a2_dlx_ff, a2_dly_ff;

   logic               a3_v_ff;
   logic [SLOT_W-1:0]  a3_slot_ff;
   point_type          a3_pt_ff, a3_pt_in;
   point_type          adv_pt_c;

   // pixel pipeline
   pix_tag_type        pp_in_tag;
   pix_tag_type        pp_out_tag;
   logic [15:0]        pp_value;
   logic [GSUM_W-1:0]  gs_c;
   logic [7:0]         gcl_c;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;
   assign step_q_c  = div10k({8'd0, csr_wdata});

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_ff  <= BLEND_ALT_A;
         gcount_ff <= 4'd3;
         ppg_ff    <= 7'd32;
         step_ff   <= '0;
         step_q_ff <= '0;
         step_r_ff <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_BLEND_MODE:       blend_ff  <= csr_wdata[1:0];
               CSR_GROUP_COUNT:      gcount_ff <= csr_wdata[3:0];
               CSR_POINTS_PER_GROUP: ppg_ff    <= csr_wdata[6:0];
               CSR_STEP_SIZE: begin
                  step_ff   <= csr_wdata;
                  step_q_ff <= step_q_c[10:0];
               end
               default: ;
            endcase
         end
         step_r_ff <= 14'(step_ff - ({13'd0, step_q_ff} * 24'd10000));
      end
   end

   assign act_gc   = (gcount_ff > GC_W'(MAX_GROUPS)) ? GC_W'(MAX_GROUPS) : GC_W'(gcount_ff);
   assign act_pc   = (ppg_ff > PC_W'(MAX_POINTS)) ? PC_W'(MAX_POINTS) : PC_W'(ppg_ff);
   assign total_c  = TOT_W'(act_gc) * TOT_W'(act_pc);
   assign last_p_c = (PC_W'(sp_ff) == (act_pc - PC_W'(1)));
   assign last_g_c = (GC_W'(sg_ff) == (act_gc - GC_W'(1)));
   assign alt_mode = (blend_ff == BLEND_ALT_A) || (blend_ff == BLEND_ALT_B);

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // load path
   assign load_we   = accept && (req_op == OP_LOAD) && (int'(req_group_index) < MAX_GROUPS)
                      && (int'(req_point_index) < MAX_POINTS);
   assign load_slot = SLOT_W'(req_group_index) * SLOT_W'(MAX_POINTS)
                      + SLOT_W'(req_point_index);
   assign load_pt.x      = {8'd0, req_pos_x};
   assign load_pt.y      = {8'd0, req_pos_y};
   assign load_pt.fine_x = {21'd0, req_pos_x} * 32'd10000;
   assign load_pt.fine_y = {21'd0, req_pos_y} * 32'd10000;
   assign load_pt.radius = {8'd0, req_radius_in};
   assign load_pt.frc    = req_force_in;
   assign load_pt.dir_x  = req_dir_x;
   assign load_pt.dir_y  = req_dir_y;

   assign rd_addr = SLOT_W'(sg_ff) * SLOT_W'(MAX_POINTS) + SLOT_W'(sp_ff);
   assign wr_en   = load_we || a3_v_ff;
   assign wr_addr = load_we ? load_slot : a3_slot_ff;
   assign wr_pt   = load_we ? load_pt : adv_pt_c;

   rse_ram #(
      .WIDTH (POINT_W),
      .DEPTH (SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_pt),
      .rd_addr (rd_addr),
      .rd_data (rd_bits)
   );

   assign rd_pt = point_type'(rd_bits);

   // advance stage 1: direction products, force test, radius shrink
   assign ax_c  = $signed(rd_pt.dir_x) * $signed({1'b0, step_q_ff});
   assign ay_c  = $signed(rd_pt.dir_y) * $signed({1'b0, step_q_ff});
   assign mdx_c = rd_pt.dir_x[14] ? (~rd_pt.dir_x + 15'd1) : rd_pt.dir_x;
   assign mdy_c = rd_pt.dir_y[14] ? (~rd_pt.dir_y + 15'd1) : rd_pt.dir_y;
   assign bx_c  = {13'd0, mdx_c} * {14'd0, step_r_ff};
   assign by_c  = {13'd0, mdy_c} * {14'd0, step_r_ff};
   assign dec_c = $signed({7'd0, rd_pt.frc}) > $signed({rd_pt.radius[31], rd_pt.radius});
   assign rad_c = $signed({rd_pt.radius[31], rd_pt.radius}) - $signed({9'd0, step_ff});

   // advance stage 2: movement deltas
   assign bqx_c = div10k({4'd0, a1_bx_ff});
   assign bqy_c = div10k({4'd0, a1_by_ff});
   assign dlx_c = {{5{a1_ax_ff[26]}}, a1_ax_ff}
                  + (a1_pt_ff.dir_x[14] ? (~{13'd0, bqx_c} + 32'd1) : {13'd0, bqx_c});
   assign dly_c = {{5{a1_ay_ff[26]}}, a1_ay_ff}
                  + (a1_pt_ff.dir_y[14] ? (~{13'd0, bqy_c} + 32'd1) : {13'd0, bqy_c});

   always_comb begin
      a2_pt_in        = a1_pt_ff;
      a2_pt_in.frc    = a1_dec_ff ? decay(a1_pt_ff.frc) : a1_pt_ff.frc;
      a2_pt_in.radius = a1_rad_ff;
      a3_pt_in        = a2_pt_ff;
      a3_pt_in.fine_x = a2_pt_ff.fine_x + a2_dlx_ff;
      a3_pt_in.fine_y = a2_pt_ff.fine_y + a2_dly_ff;
   end

   // write-back: whole-pixel position
   always_comb begin
      adv_pt_c   = a3_pt_ff;
      adv_pt_c.x = sdiv10k(a3_pt_ff.fine_x);
      adv_pt_c.y = sdiv10k(a3_pt_ff.fine_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a1_v_ff <= 1'b0;
         a2_v_ff <= 1'b0;
         a3_v_ff <= 1'b0;
      end else begin
         a1_v_ff <= iss_ff.adv;
         a2_v_ff <= a1_v_ff;
         a3_v_ff <= a2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      a1_slot_ff <= iss_ff.slot;
      a1_pt_ff   <= rd_pt;
      a1_ax_ff   <= ax_c;
      a1_ay_ff   <= ay_c;
      a1_bx_ff   <= bx_c;
      a1_by_ff   <= by_c;
      a1_dec_ff  <= dec_c;
      a1_rad_ff  <= (rad_c < -33'sd2147483648) ? 32'h8000_0000 : rad_c[31:0];

      a2_slot_ff <= a1_slot_ff;
      a2_pt_ff   <= a2_pt_in;
      a2_dlx_ff  <= dlx_c;
      a2_dly_ff  <= dly_c;

      a3_slot_ff <= a2_slot_ff;
      a3_pt_ff   <= a3_pt_in;
   end

   // pixel pipeline
   assign pp_in_tag.valid = iss_ff.rnd;
   assign pp_in_tag.last  = iss_ff.last;
   assign pp_in_tag.odd   = iss_ff.odd;

   rse_pix_pipe u_pix (
      .clock     (clock),
      .reset     (reset),
      .in_tag    (pp_in_tag),
      .in_pt     (rd_pt),
      .pix_x     (px_ff),
      .pix_y     (py_ff),
      .out_tag   (pp_out_tag),
      .out_value (pp_value)
   );

   assign gs_c  = gsum_ff + GSUM_W'(pp_value);
   assign gcl_c = (gs_c > GSUM_W'(255)) ? 8'd255 : gs_c[7:0];

   always_comb begin
      if (alt_mode) begin
         if (acc_ff < 13'sd0) begin
            final_c = 8'd0;
         end else if (acc_ff > 13'sd255) begin
            final_c = 8'd255;
         end else begin
            final_c = acc_ff[7:0];
         end
      end else begin
         final_c = avg_div(acc_ff[10:0], act_gc);
      end
   end

   always_comb begin
      state_in     = state_ff;
      sg_in        = sg_ff;
      sp_in        = sp_ff;
      rnd_in       = rnd_ff;
      total_in     = total_ff;
      retired_in   = retired_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      acc_in       = acc_ff;
      gsum_in      = gsum_ff;
      iss_in       = '0;
      iss_in.slot  = rd_addr;
      iss_in.last  = last_p_c;
      iss_in.odd   = alt_mode && sg_ff[0];
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_int_in   = rsp_int_ff;

      if (a3_v_ff || pp_out_tag.valid) begin
         retired_in = retired_ff + TOT_W'(1);
      end
      if (pp_out_tag.valid) begin
         if (pp_out_tag.last) begin
            gsum_in = '0;
            acc_in  = pp_out_tag.odd ? (acc_ff - $signed({5'd0, gcl_c}))
                                     : (acc_ff + $signed({5'd0, gcl_c}));
         end else begin
            gsum_in = gs_c;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && ((req_op == OP_ADVANCE) || (req_op == OP_RENDER))) begin
               sg_in      = '0;
               sp_in      = '0;
               total_in   = total_c;
               retired_in = '0;
               acc_in     = '0;
               gsum_in    = '0;
               px_in      = req_pos_x;
               py_in      = req_pos_y;
               rnd_in     = (req_op == OP_RENDER);
               if (total_c == '0) begin
                  state_in = ST_DRAIN;
               end else if (req_op == OP_RENDER) begin
                  state_in = ST_RND;
               end else begin
                  state_in = ST_ADV;
               end
            end
         end
         ST_ADV, ST_RND: begin
            iss_in.adv = (state_ff == ST_ADV);
            iss_in.rnd = (state_ff == ST_RND);
            if (last_p_c) begin
               sp_in = '0;
               sg_in = sg_ff + GRP_W'(1);
               if (last_g_c) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               sp_in = sp_ff + PT_W'(1);
            end
         end
         ST_DRAIN: begin
            if (retired_ff == total_ff) begin
               state_in = rnd_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_int_in   = final_c;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sg_ff        <= '0;
         sp_ff        <= '0;
         rnd_ff       <= 1'b0;
         total_ff     <= '0;
         retired_ff   <= '0;
         iss_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sg_ff        <= sg_in;
         sp_ff        <= sp_in;
         rnd_ff       <= rnd_in;
         total_ff     <= total_in;
         retired_ff   <= retired_in;
         iss_ff       <= iss_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff      <= px_in;
      py_ff      <= py_in;
      acc_ff     <= acc_in;
      gsum_ff    <= gsum_in;
      rsp_int_ff <= rsp_int_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_intensity = rsp_int_ff;
endmodule
